// ----- design/tfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared type and byte codes for the triple-0xFF line deframer.
// ----------------------------------------------------------------------------
package tfd_pkg;

    localparam logic [7:0] BYTE_TERM      = 8'hFF;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_PRINTABLE = 8'h20;
    localparam logic [7:0] BYTE_NUL       = 8'h00;
    localparam logic [1:0] TERM_RUN_LAST  = 2'd2;

    // Emission request from the framer to the readout sequencer
    typedef struct packed {
        logic start;
        logic empty;
    } emit_ctl_t;

endpackage : tfd_pkg
`default_nettype wire

// ----- design/tfd_line_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_line_mem
// Line buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tfd_line_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : tfd_line_mem
`default_nettype wire

// ----- design/tfd_framer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_framer
// Classifies each received byte, tracks the line state and terminator run,
// writes bytes into the line buffer and requests emission of finished lines.
// ----------------------------------------------------------------------------
module tfd_framer
    import tfd_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    byte_data,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [7:0]         wr_data,
    output emit_ctl_t          emit_ctl,
    output logic [AW-1:0]      emit_count
);

    localparam logic [AW-1:0] LEN_MAX = AW'(DEPTH - 1);

    logic [AW-1:0] len_reg, len_next;
    logic [1:0]    run_reg, run_next;
    logic          disc_reg, disc_next;
    logic          prn_reg, prn_next;
    logic          fz_seen_reg, fz_seen_next;
    logic [AW-1:0] fz_pos_reg, fz_pos_next;
    logic          emit;
    logic [AW-1:0] count;

    // Emission stops before the first zero byte of the line
    assign count = fz_seen_reg ? fz_pos_reg : len_reg;

    always_comb begin
        len_next     = len_reg;
        run_next     = run_reg;
        disc_next    = disc_reg;
        prn_next     = prn_reg;
        fz_seen_next = fz_seen_reg;
        fz_pos_next  = fz_pos_reg;
        emit         = 1'b0;
        wr_en        = 1'b0;
        if (byte_valid) begin
            if (byte_data == BYTE_TERM) begin
                if (run_reg == TERM_RUN_LAST) begin
                    run_next = '0;
                    if (disc_reg || len_reg != '0) begin
                        emit         = !disc_reg && prn_reg;
                        disc_next    = 1'b0;
                        len_next     = '0;
                        prn_next     = 1'b0;
                        fz_seen_next = 1'b0;
                    end
                end else begin
                    run_next = run_reg + 2'd1;
                end
            end else begin
                run_next = '0;
                if (!disc_reg) begin
                    if (byte_data == BYTE_LF) begin
                        emit         = 1'b1;
                        len_next     = '0;
                        prn_next     = 1'b0;
                        fz_seen_next = 1'b0;
                    end else if (byte_data != BYTE_CR) begin
                        if (len_reg != LEN_MAX) begin
                            wr_en    = 1'b1;
                            len_next = len_reg + AW'(1);
                            if (byte_data >= BYTE_PRINTABLE) begin
                                prn_next = 1'b1;
                            end
                            if (byte_data == BYTE_NUL && !fz_seen_reg) begin
                                fz_seen_next = 1'b1;
                                fz_pos_next  = len_reg;
                            end
                        end else begin
                            // overflow: drop the line, skip to the next triple-0xFF terminator
                            len_next     = '0;
                            prn_next     = 1'b0;
                            fz_seen_next = 1'b0;
                            disc_next    = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign wr_addr        = len_reg;
    assign wr_data        = byte_data;
    assign emit_ctl.start = emit;
    assign emit_ctl.empty = (count == '0);
    assign emit_count     = count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            run_reg     <= '0;
            disc_reg    <= 1'b0;
            prn_reg     <= 1'b0;
            fz_seen_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            run_reg     <= run_next;
            disc_reg    <= disc_next;
            prn_reg     <= prn_next;
            fz_seen_reg <= fz_seen_next;
        end
        fz_pos_reg <= fz_pos_next;
    end

endmodule : tfd_framer
`default_nettype wire

// ----- design/tfd_reader.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tfd_reader
// Reads a finished line out of the buffer one byte at a time into the
// output register; an empty line gives a single flagged transaction.
// ----------------------------------------------------------------------------
module tfd_reader
    import tfd_pkg::*;
#(
    parameter int AW = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire emit_ctl_t     emit_ctl,
    input  wire logic [AW-1:0] emit_count,
    output logic               busy,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  wire logic [7:0]    rd_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_line_char,
    output logic               m_line_last,
    output logic               m_line_empty
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_EMPTY
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] cnt_reg;
    logic          valid_reg;
    logic [7:0]    char_reg;
    logic          last_reg;
    logic          empty_reg;
    logic          out_free;
    logic          is_last;
    logic          load_out;

    assign out_free = !valid_reg || m_ready;
    assign is_last  = (idx_reg + AW'(1)) == cnt_reg;
    assign load_out = out_free && (state_reg == ST_LOAD || state_reg == ST_EMPTY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (emit_ctl.start) begin
                        idx_reg   <= '0;
                        cnt_reg   <= emit_count;
                        state_reg <= emit_ctl.empty ? ST_EMPTY : ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (out_free) begin
                        char_reg  <= rd_data;
                        last_reg  <= is_last;
                        empty_reg <= 1'b0;
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= is_last ? ST_IDLE : ST_READ;
                    end
                end
                ST_EMPTY: begin
                    if (out_free) begin
                        char_reg  <= '0;
                        last_reg  <= 1'b1;
                        empty_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign rd_en        = (state_reg == ST_READ);
    assign rd_addr      = idx_reg;
    assign m_valid      = valid_reg;
    assign m_line_char  = char_reg;
    assign m_line_last  = last_reg;
    assign m_line_empty = empty_reg;

endmodule : tfd_reader
`default_nettype wire

// ----- design/triple_ff_line_deframer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// triple_ff_line_deframer
// Serial line deframer: lines end in newline or three 0xFF bytes.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction and builds the current line in a
// single-port-read line buffer. Bytes that emit nothing are taken back to
// back while no line is being read out. When a line is emitted, input is
// held off while it is read out: each byte is read from the buffer, then
// loaded into the output register, and an empty line loads one flagged
// transaction; a stall on the result side holds the load. The output
// register keeps the last byte of a line while the next bytes are taken.
// ----------------------------------------------------------------------------
module triple_ff_line_deframer
    import tfd_pkg::*;
#(
    parameter int LINE_BUF_SIZE = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_line_char,
    output logic            m_line_last,
    output logic            m_line_empty
);

    localparam int AW = (LINE_BUF_SIZE > 2) ? $clog2(LINE_BUF_SIZE) : 1;

    logic          busy;
    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    emit_ctl_t     emit_ctl;
    logic [AW-1:0] emit_count;

    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;

    tfd_framer #(
        .DEPTH (LINE_BUF_SIZE),
        .AW    (AW)
    ) u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (accept),
        .byte_data  (s_rx_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .emit_ctl   (emit_ctl),
        .emit_count (emit_count)
    );

    tfd_line_mem #(
        .DEPTH (LINE_BUF_SIZE),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tfd_reader #(
        .AW (AW)
    ) u_reader (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .emit_ctl     (emit_ctl),
        .emit_count   (emit_count),
        .busy         (busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_char  (m_line_char),
        .m_line_last  (m_line_last),
        .m_line_empty (m_line_empty)
    );

    // buffer is never written while a line is being read out
    a_no_write_in_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !busy)
        else $error("line buffer written during readout");

    a_no_read_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> busy)
        else $error("buffer read outside readout");

    a_emit_starts_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_ctl.start |=> busy)
        else $error("emission request did not start readout");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_line_empty) |-> (m_line_last && m_line_char == 8'h00))
        else $error("empty line transaction malformed");

endmodule : triple_ff_line_deframer
`default_nettype wire

// ----- test/tb_triple_ff_line_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_triple_ff_line_deframer
// Self-checking bench for the triple-0xFF serial line deframer.
// ----------------------------------------------------------------------------
// Bytes are driven one transaction at a time. A behavioural line model runs
// alongside and queues the expected line bytes, which are checked in order
// against the result channel. A short table of corner cases comes first,
// followed by random lines, overflows, unprintable lines and noise, with
// idle bursts on both channels for most of the run.
// ----------------------------------------------------------------------------
module tb_triple_ff_line_deframer;
    import tfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH   = 64;
    localparam int NUL_NONE    = 127;
    localparam int ITEMS       = 350;
    localparam int QUIET_AFTER = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 32;
    localparam int DIR_ROWS    = 26;

    typedef struct packed {
        logic [7:0] chr;
        logic       last;
        logic       empty;
    } line_res_t;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        line_res_t  res;
    } dir_row_t;

    localparam line_res_t NO_RES = '{8'h00, 1'b0, 1'b0};

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_data = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_line_char;
    logic       m_line_last;
    logic       m_line_empty;

    triple_ff_line_deframer uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_data   (s_rx_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_line_char (m_line_char),
        .m_line_last (m_line_last),
        .m_line_empty(m_line_empty)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // line model state
    logic [7:0] line_mem [BUF_DEPTH];
    int         cur_len   = 0;
    int         ff_run    = 0;
    bit         dropping  = 1'b0;
    bit         has_print = 1'b0;
    int         nul_pos   = NUL_NONE;
    bit         byte_used;

    line_res_t  step_out [$];
    line_res_t  line_q [$];
    dir_row_t   dir_tab [DIR_ROWS];

    bit bursts_on   = 1'b1;
    int err_count   = 0;
    int bytes_sent  = 0;
    int bytes_used  = 0;
    int lines_due   = 0;
    int overflows   = 0;
    int res_checked = 0;
    int lines_seen  = 0;
    int quiet_cnt   = 0;

    function automatic void clear_line();
        cur_len   = 0;
        has_print = 1'b0;
        nul_pos   = NUL_NONE;
    endfunction

    function automatic void emit_line();
        int n;
        n = cur_len;
        if (nul_pos < n) n = nul_pos;
        if (n > BUF_DEPTH - 1) n = BUF_DEPTH - 1;
        lines_due++;
        if (n == 0) begin
            step_out.push_back('{BYTE_NUL, 1'b1, 1'b1});
        end else begin
            for (int i = 0; i < n; i++)
                step_out.push_back('{line_mem[i], (i == n - 1), 1'b0});
        end
    endfunction

    // Advance the line model by one byte; results land in step_out.
    function automatic void predict_byte(input logic [7:0] b);
        step_out.delete();
        byte_used = 1'b1;
        if (b == BYTE_TERM) begin
            ff_run++;
            if (ff_run >= 3) begin
                ff_run = 0;
                if (dropping) begin
                    dropping = 1'b0;
                    clear_line();
                end else if (cur_len > 0) begin
                    if (has_print) emit_line();
                    clear_line();
                end
            end
            return;
        end
        ff_run = 0;
        if (dropping || b == BYTE_CR) begin
            byte_used = 1'b0;
            return;
        end
        if (b == BYTE_LF) begin
            emit_line();
            clear_line();
            return;
        end
        if (cur_len + 1 < BUF_DEPTH) begin
            line_mem[cur_len] = b;
            if (b >= BYTE_PRINTABLE) has_print = 1'b1;
            if (b == BYTE_NUL && nul_pos == NUL_NONE) nul_pos = cur_len;
            cur_len++;
        end else begin
            clear_line();
            dropping = 1'b1;
            overflows++;
        end
    endfunction

    // Called just after a falling edge; returns just after a later falling edge, once the byte is taken.
    task automatic push_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input line_res_t res = NO_RES);
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(b);
        if (typed) begin
            step_out.delete();
            step_out.push_back(res);
        end
        foreach (step_out[i]) line_q.push_back(step_out[i]);
        bytes_sent++;
        if (byte_used) bytes_used++;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        case ($urandom_range(0, 19))
            0:       b = BYTE_NUL;
            1:       b = BYTE_CR;
            2:       b = BYTE_TERM;
            3:       b = 8'($urandom_range(0, 31));
            default: b = 8'($urandom_range(32, 254));
        endcase
        if (b == BYTE_LF) b = 8'h09;
        return b;
    endfunction

    task automatic push_term();
        repeat (3) push_byte(BYTE_TERM);
    endtask

    task automatic run_sequence(input int kind);
        int n;
        logic [7:0] b;
        case (kind)
            6, 7: begin
                // long line, or one that overruns the buffer and is discarded
                n = (kind == 7) ? $urandom_range(64, 68) : $urandom_range(30, 63);
                repeat (n) push_byte(8'($urandom_range(32, 254)));
                if (kind == 7) begin
                    push_byte(BYTE_LF);
                    push_byte(8'($urandom_range(0, 254)));
                    push_byte(BYTE_CR);
                    push_term();
                end else if ($urandom_range(0, 1)) begin
                    push_byte(BYTE_LF);
                end else begin
                    push_term();
                end
            end
            8: begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
            end
            9: begin
                // nothing printable: dropped at the terminator
                repeat ($urandom_range(1, 8)) begin
                    b = 8'($urandom_range(0, 31));
                    if (b == BYTE_LF) b = BYTE_CR;
                    push_byte(b);
                end
                push_term();
            end
            default: begin
                repeat ($urandom_range(0, 12)) push_byte(body_byte());
                if ($urandom_range(0, 1)) push_byte(BYTE_LF);
                else push_term();
            end
        endcase
    endtask

    // result side back-pressure
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (bursts_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        line_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (line_q.size() == 0) begin
                $error("unexpected result: line_char %h last %b empty %b",
                       m_line_char, m_line_last, m_line_empty);
                err_count++;
            end else begin
                want = line_q.pop_front();
                res_checked++;
                if (m_line_char !== want.chr) begin
                    $error("line_char: expected %h, got %h", want.chr, m_line_char);
                    err_count++;
                end
                if (m_line_last !== want.last) begin
                    $error("line_last: expected %b, got %b", want.last, m_line_last);
                    err_count++;
                end
                if (m_line_empty !== want.empty) begin
                    $error("line_empty: expected %b, got %b", want.empty, m_line_empty);
                    err_count++;
                end
                if (want.last) lines_seen++;
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    initial begin
        dir_tab = '{
            // newline on an empty line
            '{BYTE_LF,   1'b1, '{BYTE_NUL, 1'b1, 1'b1}},
            // output stops at the zero byte
            '{8'h41,     1'b0, NO_RES},
            '{BYTE_NUL,  1'b0, NO_RES},
            '{8'h42,     1'b0, NO_RES},
            '{BYTE_LF,   1'b1, '{8'h41, 1'b1, 1'b0}},
            // zero first, printable after it: empty line
            '{BYTE_NUL,  1'b0, NO_RES},
            '{8'h7E,     1'b0, NO_RES},
            '{BYTE_TERM, 1'b0, NO_RES},
            '{BYTE_TERM, 1'b0, NO_RES},
            '{BYTE_TERM, 1'b1, '{BYTE_NUL, 1'b1, 1'b1}},
            // CRs dropped, lowest printable
            '{BYTE_CR,   1'b0, NO_RES},
            '{BYTE_PRINTABLE, 1'b0, NO_RES},
            '{BYTE_CR,   1'b0, NO_RES},
            '{BYTE_TERM, 1'b0, NO_RES},
            '{BYTE_TERM, 1'b0, NO_RES},
            '{BYTE_TERM, 1'b1, '{BYTE_PRINTABLE, 1'b1, 1'b0}},
            // terminator on an empty line
            '{BYTE_TERM, 1'b0, NO_RES},
            '{BYTE_TERM, 1'b0, NO_RES},
            '{BYTE_TERM, 1'b0, NO_RES},
            // unprintable line is dropped
            '{8'h01,     1'b0, NO_RES},
            '{BYTE_TERM, 1'b0, NO_RES},
            '{BYTE_TERM, 1'b0, NO_RES},
            '{BYTE_TERM, 1'b0, NO_RES},
            // lone 0xFF broken by a newline
            '{8'hFE,     1'b0, NO_RES},
            '{BYTE_TERM, 1'b0, NO_RES},
            '{BYTE_LF,   1'b0, NO_RES}
        };

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i]) push_byte(dir_tab[i].data, dir_tab[i].typed, dir_tab[i].res);

        // first random sequence is always an overflow
        run_sequence(7);
        while (bytes_sent < ITEMS) begin
            if (bytes_sent >= QUIET_AFTER) bursts_on = 1'b0;
            run_sequence($urandom_range(0, 9));
        end
        bursts_on = 1'b0;
        s_valid <= 1'b0;

        while (line_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Drove %0d bytes (%0d took effect), %0d buffer overflows.",
                 bytes_sent, bytes_used, overflows);
        $display("Checked %0d result bytes across %0d lines (%0d predicted).",
                 res_checked, lines_seen, lines_due);
        if (err_count == 0 && line_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/tfd_pkg.sv
design/tfd_line_mem.sv
design/tfd_framer.sv
design/tfd_reader.sv
design/triple_ff_line_deframer.sv
test/tb_triple_ff_line_deframer.sv
